// ----- src/lrcp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRC timestamp line parser: shared definitions
// Types, character codes and limits used by the controller, datapath and the
// result stage.
// ----------------------------------------------------------------------------
package lrcp_pkg;

  // Tag buffer and per-line stamp limits
  localparam int TAG_MAX         = 16;
  localparam int STAMPS_PER_LINE = 8;
  localparam int TAG_LEN_W       = $clog2(TAG_MAX + 1);
  localparam int TAG_IDX_W       = $clog2(TAG_MAX);
  localparam int LSC_W           = 4;

  // Stream widths
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 48;
  localparam int OUT_USER_W = 2;

  // Configuration port
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_ADDR_W-1:0] REG_ENTRY_LIMIT = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_TEXT_LIMIT  = 1'd1;
  localparam logic [15:0] ENTRY_LIMIT_RST = 16'd256;
  localparam logic [7:0]  TEXT_LIMIT_RST  = 8'd63;

  // Arithmetic limits
  localparam logic [15:0] MIN_SAT    = 16'hFFFF;
  localparam logic [21:0] SEC_SAT    = 22'h3F_FFFF;
  localparam logic [31:0] MS_PER_MIN = 32'd60000;
  localparam logic [31:0] MS_PER_SEC = 32'd1000;
  localparam logic [30:0] TIME_MAX   = 31'h7FFF_FFFF;
  localparam logic [1:0]  FRAC_DIGITS_MAX = 2'd3;

  // Character codes
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_LBRK  = 8'h5B;
  localparam logic [7:0] CH_RBRK  = 8'h5D;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_TAG  = 3'd1,
    PH_MIN  = 3'd2,
    PH_SEC  = 3'd3,
    PH_FRAC = 3'd4,
    PH_TRIM = 3'd5,
    PH_TEXT = 3'd6,
    PH_SKIP = 3'd7
  } phase_t;

  typedef enum logic [1:0] {
    KIND_STAMP = 2'd0,
    KIND_TEXT  = 2'd1,
    KIND_LEND  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_RUN    = 3'd0,
    ST_STAMP  = 3'd1,
    ST_REPLAY = 3'd2,
    ST_CHAR   = 3'd3,
    ST_LEND   = 3'd4,
    ST_FLUSH  = 3'd5
  } ctrl_state_t;

  typedef enum logic [2:0] {
    OP_NONE   = 3'd0,
    OP_PARSE  = 3'd1,
    OP_STAMP  = 3'd2,
    OP_REPLAY = 3'd3,
    OP_CHAR   = 3'd4,
    OP_LEND   = 3'd5,
    OP_FLUSH  = 3'd6
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   done;     // last micro-step of the current item
  } dp_cmd_t;

  typedef struct packed {
    logic crlf;         // incoming byte ends a line
    logic run_stamp;    // incoming byte closes a tag
    logic run_replay;   // incoming byte fails a later tag
    logic lend_replay;  // line end inside a later tag
    logic rp_last;      // replay pointer on its last step
    logic eob;          // latched end of blob
  } dp_stat_t;

  typedef struct packed {
    kind_t             kind;
    logic [30:0]       time_ms;
    logic [7:0]        text_char;
    logic [LSC_W-1:0]  stamps;
  } res_t;

endpackage

// ----- src/lrc_timestamp_line_parser_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRC timestamp line parser
// Byte stream in, timestamp / text / line-end results out.
// ----------------------------------------------------------------------------
// Input channel in_*: one text byte per item; in_tlast marks the final byte of
// a blob. Output channel out_*: one result per item, kind in out_tuser
// (0 timestamp, 1 text byte, 2 line end); out_tlast marks the final result
// that an input byte causes. Bytes that cause no result produce no item.
// Text and tag body bytes take only the parse step; the result is registered
// in the result stage. A closing bracket adds a timestamp step (registered
// products), a CR or LF a line-end and a flush step, a line end inside a
// later tag also a replay of the held bytes, and a byte that fails a later
// tag, the first text byte after the tags included, a replay of the held
// bytes, a step for the byte itself and a flush. A final blob byte closes its
// line too with a line-end step, none after CR or LF. All set by the sequencer.
// Reset sets entry_limit to 256, text_limit to 63 and leaves the parser at
// the start of a line. While out_tready is low a full result register holds,
// the sequencer freezes and in_tready drops. Write the cfg_* registers only
// while no item is in flight.
// ----------------------------------------------------------------------------
module lrc_timestamp_line_parser_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [lrcp_pkg::IN_DATA_W-1:0]      in_tdata,   // [7:0] char_in
  input  logic                                in_tlast,   // end_of_blob
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [30:0] time_ms, [38:31] text_char, [42:39] stamps_in_line, [47:43] zero
  output logic [lrcp_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic [lrcp_pkg::OUT_USER_W-1:0]     out_tuser,  // [1:0] kind
  output logic                                out_tlast,  // last
  input  logic                                cfg_we,
  input  logic [lrcp_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [lrcp_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import lrcp_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     out_free;
  logic     res_valid;
  res_t     res;

  lrcp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tlast  (in_tlast),
    .stat      (stat),
    .out_free  (out_free),
    .in_tready (in_tready),
    .cmd       (cmd)
  );

  lrcp_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_char   (in_tdata),
    .in_eob    (in_tlast),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .stat      (stat),
    .res_valid (res_valid),
    .res       (res)
  );

  lrcp_outq u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .res_valid  (res_valid),
    .res        (res),
    .out_free   (out_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

// ----- src/lrcp_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRC parser controller
// Sequences the micro-steps of one item: parse, timestamp, replay, failing
// byte, line end and final flush. Advances only while the result stage is free.
// ----------------------------------------------------------------------------
module lrcp_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  input  logic               in_tlast,
  input  lrcp_pkg::dp_stat_t stat,
  input  logic               out_free,
  output logic               in_tready,
  output lrcp_pkg::dp_cmd_t  cmd
);
  import lrcp_pkg::*;

  ctrl_state_t state_r, state_nxt;
  logic        ret_char_r, ret_char_nxt;
  logic        accept;

  assign accept = (state_r == ST_RUN) && out_free && in_tvalid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_RUN;
      ret_char_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      ret_char_r <= ret_char_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt    = state_r;
    ret_char_nxt = ret_char_r;
    unique case (state_r)
      ST_RUN: begin
        if (accept) begin
          if (stat.crlf) begin
            state_nxt = ST_LEND;
          end else if (stat.run_stamp) begin
            state_nxt = ST_STAMP;
          end else if (stat.run_replay) begin
            state_nxt    = ST_REPLAY;
            ret_char_nxt = 1'b1;
          end else if (in_tlast) begin
            state_nxt = ST_LEND;
          end
        end
      end
      ST_STAMP: begin
        if (out_free) begin
          state_nxt = stat.eob ? ST_LEND : ST_RUN;
        end
      end
      ST_REPLAY: begin
        if (out_free && stat.rp_last) begin
          state_nxt = ret_char_r ? ST_CHAR : ST_LEND;
        end
      end
      ST_CHAR: begin
        if (out_free) begin
          state_nxt = stat.eob ? ST_LEND : ST_FLUSH;
        end
      end
      ST_LEND: begin
        if (out_free) begin
          if (stat.lend_replay) begin
            state_nxt    = ST_REPLAY;
            ret_char_nxt = 1'b0;
          end else begin
            state_nxt = ST_FLUSH;
          end
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          state_nxt = ST_RUN;
        end
      end
      default: state_nxt = ST_RUN;
    endcase
  end

  // outputs
  always_comb begin
    in_tready = 1'b0;
    cmd.op    = OP_NONE;
    cmd.done  = 1'b0;
    unique case (state_r)
      ST_RUN: begin
        in_tready = out_free;
        if (accept) begin
          cmd.op   = OP_PARSE;
          cmd.done = !(stat.crlf || stat.run_stamp || stat.run_replay || in_tlast);
        end
      end
      ST_STAMP: begin
        if (out_free) begin
          cmd.op   = OP_STAMP;
          cmd.done = !stat.eob;
        end
      end
      ST_REPLAY: begin
        if (out_free) cmd.op = OP_REPLAY;
      end
      ST_CHAR: begin
        if (out_free) cmd.op = OP_CHAR;
      end
      ST_LEND: begin
        if (out_free) cmd.op = OP_LEND;
      end
      ST_FLUSH: begin
        if (out_free) begin
          cmd.op   = OP_FLUSH;
          cmd.done = 1'b1;
        end
      end
      default: cmd.op = OP_NONE;
    endcase
  end

endmodule

// ----- src/lrcp_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRC parser datapath
// Parser state, tag accumulators, tag byte buffer, millisecond arithmetic,
// text trimming and limits, configuration registers. Raises at most one
// result per micro-step.
// ----------------------------------------------------------------------------
module lrcp_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [lrcp_pkg::IN_DATA_W-1:0]      in_char,
  input  logic                                in_eob,
  input  logic                                cfg_we,
  input  logic [lrcp_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [lrcp_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  lrcp_pkg::dp_cmd_t                   cmd,
  output lrcp_pkg::dp_stat_t                  stat,
  output logic                                res_valid,
  output lrcp_pkg::res_t                      res
);
  import lrcp_pkg::*;

  phase_t                phase_r, phase_nxt;
  logic [15:0]           min_r, min_nxt;
  logic [21:0]           sec_r, sec_nxt;
  logic [9:0]            frac_r, frac_nxt;
  logic [1:0]            fdig_r, fdig_nxt;
  logic [LSC_W-1:0]      lsc_r, lsc_nxt;
  logic [LSC_W-1:0]      emt_r, emt_nxt;
  logic [15:0]           ent_r, ent_nxt;
  logic [7:0]            txt_r, txt_nxt;
  logic [TAG_LEN_W-1:0]  tlen_r, tlen_nxt;
  logic [TAG_LEN_W-1:0]  ptr_r, ptr_nxt;
  logic                  ign_r, ign_nxt;
  logic [7:0]            c_r, c_nxt;
  logic                  eob_r, eob_nxt;
  logic [15:0]           elim_r, elim_nxt;
  logic [7:0]            tlim_r, tlim_nxt;
  logic [7:0]            buf_r [TAG_MAX];
  logic                  buf_we;
  logic [TAG_IDX_W-1:0]  buf_waddr;

  logic [31:0]           prod_min_r, prod_min_nxt;
  logic [31:0]           prod_sec_r, prod_sec_nxt;
  logic [9:0]            fms_r, fms_nxt;
  logic [32:0]           stamp_sum;
  logic [30:0]           stamp_ms;

  logic                  crlf, is_digit, below_limit, p_active;
  logic                  in_tagph, is_close, tag_byte_ok, fail, in_tag_now;
  logic [3:0]            digit;
  phase_t                eff;
  logic [19:0]           min_step;
  logic [25:0]           sec_step;
  logic                  tb_en, tb_blank;
  logic [7:0]            tb_byte;

  // ---------------------------------------------------------------- classify
  assign crlf        = (in_char == CH_CR) || (in_char == CH_LF);
  assign is_digit    = (in_char >= CH_ZERO) && (in_char <= CH_NINE);
  assign digit       = 4'(in_char - CH_ZERO);
  assign below_limit = ent_r < elim_r;
  assign p_active    = !crlf && !ign_r && !((phase_r == PH_IDLE) && !below_limit);
  assign eff         = (phase_r == PH_IDLE) ? PH_TAG : phase_r;
  assign in_tagph    = (eff == PH_MIN) || (eff == PH_SEC) || (eff == PH_FRAC);
  assign is_close    = in_tagph && (in_char == CH_RBRK) && (eff != PH_MIN);
  assign in_tag_now  = (phase_r == PH_MIN) || (phase_r == PH_SEC) || (phase_r == PH_FRAC);
  assign min_step    = 20'(min_r) * 20'd10 + 20'(digit);
  assign sec_step    = 26'(sec_r) * 26'd10 + 26'(digit);

  always_comb begin
    case (eff)
      PH_MIN:  tag_byte_ok = is_digit || (in_char == CH_COLON);
      PH_SEC:  tag_byte_ok = is_digit || (in_char == CH_DOT) || (in_char == CH_COLON);
      PH_FRAC: tag_byte_ok = is_digit;
      default: tag_byte_ok = 1'b0;
    endcase
  end

  assign fail = p_active &&
                (((eff == PH_TAG) && (in_char != CH_LBRK)) ||
                 (in_tagph && !is_close &&
                  ((tlen_r >= TAG_LEN_W'(TAG_MAX)) || !tag_byte_ok)));

  assign stat.crlf        = crlf;
  assign stat.run_stamp   = p_active && is_close;
  assign stat.run_replay  = fail && (lsc_r != '0);
  assign stat.lend_replay = in_tag_now && (lsc_r != '0);
  assign stat.rp_last     = ({1'b0, ptr_r} + (TAG_LEN_W+1)'(1)) >= {1'b0, tlen_r};
  assign stat.eob         = eob_r;

  // ------------------------------------------------------ millisecond maths
  // Products are registered from the accumulators; they are settled by
  // the time the stamp step runs.
  always_comb begin
    case (fdig_r)
      2'd1:    fms_nxt = 10'(frac_r * 10'd100);
      2'd2:    fms_nxt = 10'(frac_r * 10'd10);
      2'd3:    fms_nxt = frac_r;
      default: fms_nxt = '0;
    endcase
  end

  assign prod_min_nxt = 32'(min_r) * MS_PER_MIN;
  assign prod_sec_nxt = 32'(sec_r) * MS_PER_SEC;
  assign stamp_sum    = 33'(prod_min_r) + 33'(prod_sec_r) + 33'(fms_r);
  assign stamp_ms     = (stamp_sum > 33'(TIME_MAX)) ? TIME_MAX : stamp_sum[30:0];

  // ------------------------------------------------------------ micro-steps
  always_comb begin
    phase_nxt = phase_r;
    min_nxt   = min_r;
    sec_nxt   = sec_r;
    frac_nxt  = frac_r;
    fdig_nxt  = fdig_r;
    lsc_nxt   = lsc_r;
    emt_nxt   = emt_r;
    ent_nxt   = ent_r;
    txt_nxt   = txt_r;
    tlen_nxt  = tlen_r;
    ptr_nxt   = ptr_r;
    ign_nxt   = ign_r;
    c_nxt     = c_r;
    eob_nxt   = eob_r;
    elim_nxt  = elim_r;
    tlim_nxt  = tlim_r;
    buf_we    = 1'b0;
    buf_waddr = tlen_r[TAG_IDX_W-1:0];
    res_valid = 1'b0;
    res       = '0;
    tb_en     = 1'b0;
    tb_byte   = in_char;

    unique case (cmd.op)
      OP_PARSE: begin
        c_nxt   = in_char;
        eob_nxt = in_eob;
        if (!crlf && !ign_r && (phase_r == PH_IDLE) && !below_limit) begin
          ign_nxt = 1'b1;
        end
        if (p_active) begin
          if (fail) begin
            if (lsc_r == '0) begin
              phase_nxt = PH_SKIP;
              tlen_nxt  = '0;
            end else begin
              // keep the held bytes for the replay
              phase_nxt = PH_TRIM;
              ptr_nxt   = '0;
            end
          end else if (eff == PH_TAG) begin
            buf_we    = 1'b1;
            buf_waddr = '0;
            tlen_nxt  = TAG_LEN_W'(1);
            min_nxt   = '0;
            sec_nxt   = '0;
            frac_nxt  = '0;
            fdig_nxt  = '0;
            phase_nxt = PH_MIN;
          end else if (is_close) begin
            phase_nxt = phase_r;
          end else if (in_tagph) begin
            buf_we   = 1'b1;
            tlen_nxt = tlen_r + TAG_LEN_W'(1);
            case (eff)
              PH_MIN: begin
                if (is_digit) min_nxt = (min_step > 20'(MIN_SAT)) ? MIN_SAT : min_step[15:0];
                else          phase_nxt = PH_SEC;
              end
              PH_SEC: begin
                if (is_digit) sec_nxt = (sec_step > 26'(SEC_SAT)) ? SEC_SAT : sec_step[21:0];
                else          phase_nxt = PH_FRAC;
              end
              default: begin
                // digits past the third are held but not counted
                if (fdig_r < FRAC_DIGITS_MAX) begin
                  frac_nxt = 10'(frac_r * 10'd10 + 10'(digit));
                  fdig_nxt = fdig_r + 2'd1;
                end
              end
            endcase
          end else if ((eff == PH_TRIM) || (eff == PH_TEXT)) begin
            tb_en = 1'b1;
          end
        end
      end
      OP_STAMP: begin
        lsc_nxt  = lsc_r + LSC_W'(1);
        tlen_nxt = '0;
        if (below_limit) begin
          res_valid   = 1'b1;
          res.kind    = KIND_STAMP;
          res.time_ms = stamp_ms;
          ent_nxt     = ent_r + 16'd1;
          emt_nxt     = emt_r + LSC_W'(1);
        end
        phase_nxt = (lsc_r >= LSC_W'(STAMPS_PER_LINE - 1)) ? PH_TRIM : PH_TAG;
      end
      OP_REPLAY: begin
        tb_en   = ptr_r < tlen_r;
        tb_byte = buf_r[ptr_r[TAG_IDX_W-1:0]];
        ptr_nxt = ptr_r + TAG_LEN_W'(1);
        if (stat.rp_last) tlen_nxt = '0;
      end
      OP_CHAR: begin
        tb_en   = 1'b1;
        tb_byte = c_r;
      end
      OP_LEND: begin
        if (stat.lend_replay) begin
          phase_nxt = PH_TRIM;
          ptr_nxt   = '0;
        end else begin
          if ((phase_r != PH_IDLE) && (phase_r != PH_SKIP) && (lsc_r != '0)) begin
            res_valid  = 1'b1;
            res.kind   = KIND_LEND;
            res.stamps = emt_r;
          end
          phase_nxt = PH_IDLE;
          lsc_nxt   = '0;
          emt_nxt   = '0;
          txt_nxt   = '0;
          tlen_nxt  = '0;
        end
      end
      OP_FLUSH: begin
        if (eob_r) begin
          ent_nxt = '0;
          ign_nxt = 1'b0;
        end
      end
      default: begin
        phase_nxt = phase_r;
      end
    endcase

    // text byte: drop leading blanks, cut at the text limit
    tb_blank = (phase_r == PH_TRIM) && ((tb_byte == CH_SPACE) || (tb_byte == CH_TAB));
    if (tb_en && !tb_blank) begin
      phase_nxt = PH_TEXT;
      if (txt_r < tlim_r) begin
        res_valid     = 1'b1;
        res.kind      = KIND_TEXT;
        res.text_char = tb_byte;
        txt_nxt       = txt_r + 8'd1;
      end
    end

    if (cfg_we) begin
      unique case (cfg_addr)
        REG_ENTRY_LIMIT: elim_nxt = cfg_wdata;
        REG_TEXT_LIMIT:  tlim_nxt = cfg_wdata[7:0];
        default:         elim_nxt = elim_r;
      endcase
    end
  end

  // --------------------------------------------------------------- registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      min_r   <= '0;
      sec_r   <= '0;
      frac_r  <= '0;
      fdig_r  <= '0;
      lsc_r   <= '0;
      emt_r   <= '0;
      ent_r   <= '0;
      txt_r   <= '0;
      tlen_r  <= '0;
      ptr_r   <= '0;
      ign_r   <= 1'b0;
      eob_r   <= 1'b0;
      elim_r  <= ENTRY_LIMIT_RST;
      tlim_r  <= TEXT_LIMIT_RST;
    end else begin
      phase_r <= phase_nxt;
      min_r   <= min_nxt;
      sec_r   <= sec_nxt;
      frac_r  <= frac_nxt;
      fdig_r  <= fdig_nxt;
      lsc_r   <= lsc_nxt;
      emt_r   <= emt_nxt;
      ent_r   <= ent_nxt;
      txt_r   <= txt_nxt;
      tlen_r  <= tlen_nxt;
      ptr_r   <= ptr_nxt;
      ign_r   <= ign_nxt;
      eob_r   <= eob_nxt;
      elim_r  <= elim_nxt;
      tlim_r  <= tlim_nxt;
    end
  end

  always_ff @(posedge clk) begin
    c_r        <= c_nxt;
    prod_min_r <= prod_min_nxt;
    prod_sec_r <= prod_sec_nxt;
    fms_r      <= fms_nxt;
    if (buf_we) buf_r[buf_waddr] <= in_char;
  end

endmodule

// ----- src/lrcp_outq.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRC parser result stage
// Holds the newest result back by one so that the last result of an item can
// be marked, and drives the registered output channel.
// ----------------------------------------------------------------------------
module lrcp_outq (
  input  logic                                clk,
  input  logic                                rst_n,
  input  lrcp_pkg::dp_cmd_t                   cmd,
  input  logic                                res_valid,
  input  lrcp_pkg::res_t                      res,
  output logic                                out_free,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [lrcp_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic [lrcp_pkg::OUT_USER_W-1:0]     out_tuser,
  output logic                                out_tlast
);
  import lrcp_pkg::*;

  logic hold_v_r, hold_v_nxt;
  res_t hold_r, hold_nxt;
  logic out_v_r, out_v_nxt;
  res_t out_r, out_nxt;
  logic last_r, last_nxt;
  logic push;

  assign out_free = !out_v_r || out_tready;

  // The controller only ends an item with a new result while the hold is
  // empty, so at most one result leaves per cycle.
  always_comb begin
    hold_v_nxt = hold_v_r;
    hold_nxt   = hold_r;
    out_nxt    = out_r;
    last_nxt   = last_r;
    push       = 1'b0;
    if (hold_v_r) begin
      if (res_valid || cmd.done) begin
        push     = 1'b1;
        out_nxt  = hold_r;
        last_nxt = cmd.done && !res_valid;
      end
      if (res_valid) begin
        hold_nxt = res;
      end else if (cmd.done) begin
        hold_v_nxt = 1'b0;
      end
    end else if (res_valid) begin
      if (cmd.done) begin
        push     = 1'b1;
        out_nxt  = res;
        last_nxt = 1'b1;
      end else begin
        hold_v_nxt = 1'b1;
        hold_nxt   = res;
      end
    end
    if (push)            out_v_nxt = 1'b1;
    else if (out_tready) out_v_nxt = 1'b0;
    else                 out_v_nxt = out_v_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      hold_v_r <= hold_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hold_r <= hold_nxt;
    out_r  <= out_nxt;
    last_r <= last_nxt;
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {(OUT_DATA_W - 43)'(0), out_r.stamps, out_r.text_char, out_r.time_ms};
  assign out_tuser  = out_r.kind;
  assign out_tlast  = last_r;

endmodule
